// ===== hw/rtl/gasp_pkg.sv =====
// ----------------------------------------------------------------------------
// gasp_pkg
// Shared types, constants and helpers of the glyph atlas shelf packer.
// ----------------------------------------------------------------------------
package gasp_pkg;

  // parameter defaults
  localparam int unsigned DEF_MAX_GLYPHS = 256;
  localparam int unsigned DEF_START_WIDTH = 256;
  localparam int unsigned DEF_MAX_WIDTH = 2048;
  localparam int unsigned DEF_MIN_SIZE = 64;

  // field widths
  localparam int unsigned GW_W = 11;
  localparam int unsigned CODE_W = 8;
  localparam int unsigned RH_W = 6;
  localparam int unsigned ATW_W = 12;
  localparam int unsigned ATH_W = 16;
  localparam int unsigned PX_W = 11;
  localparam int unsigned PY_W = 14;
  localparam int unsigned CFG_IDX_W = 8;
  localparam int unsigned CFG_DATA_W = 8;

  // row cursor during the width search, holds 1 + 256 rows of 64
  localparam int unsigned RY_W = 15;
  // power of two rounding word
  localparam int unsigned P2_W = 17;

  localparam logic [GW_W-1:0] WIDTH_SAT = 11'd2046;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_CHAR = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_HEIGHT = 8'd1;

  // input modes and result kinds
  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_QUERY = 1'b1;
  localparam logic KIND_PACK = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  typedef struct packed {
    logic              mode;
    logic [GW_W-1:0]   pix_width;
    logic              last_glyph;
    logic [CODE_W-1:0] char_code;
  } in_t;

  typedef struct packed {
    logic             result_kind;
    logic [ATW_W-1:0] atlas_width;
    logic [ATH_W-1:0] atlas_height;
    logic [PX_W-1:0]  pos_x;
    logic [PY_W-1:0]  pos_y;
    logic [GW_W-1:0]  width_out;
    logic             present;
  } out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN_RD,
    ST_SCAN_EV,
    ST_SIZE,
    ST_PLACE_RD,
    ST_PLACE_EV,
    ST_PACK_OUT,
    ST_QUERY_OUT
  } state_e;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_QUERY,
    CMD_SCAN_RD,
    CMD_SCAN_EV,
    CMD_SIZE,
    CMD_PLACE_RD,
    CMD_PLACE_EV,
    CMD_PACK_OUT,
    CMD_QUERY_OUT
  } cmd_e;

  typedef struct packed {
    cmd_e op;
  } ctrl_cmd_t;

  typedef struct packed {
    logic scan_end;
    logic out_free;
  } dp_status_t;

  // smallest power of two not below v, 1 for zero
  function automatic logic [P2_W-1:0] pow2_ceil(input logic [P2_W-1:0] v);
    logic [P2_W-1:0] p;
    p = '0;
    for (int k = P2_W - 1; k >= 0; k--) begin
      if ((P2_W'(1) << k) >= v) begin
        p = P2_W'(1) << k;
      end
    end
    return p;
  endfunction

endpackage

// ===== hw/rtl/gasp_ram.sv =====
// ----------------------------------------------------------------------------
// gasp_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module gasp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/gasp_ctrl.sv =====
// ----------------------------------------------------------------------------
// gasp_ctrl
// Sequencer of the packer: load, query, width search and placement passes.
// ----------------------------------------------------------------------------
module gasp_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_mode_i,
  input  logic                  in_last_i,
  input  gasp_pkg::dp_status_t  status_i,
  output logic                  in_ready_o,
  output gasp_pkg::ctrl_cmd_t   cmd_o
);

  gasp_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= gasp_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      gasp_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          if (in_mode_i == gasp_pkg::MODE_QUERY) begin
            state_d = gasp_pkg::ST_QUERY_OUT;
          end else if (in_last_i) begin
            state_d = gasp_pkg::ST_SCAN_RD;
          end
        end
      end
      gasp_pkg::ST_SCAN_RD: begin
        state_d = status_i.scan_end ? gasp_pkg::ST_SIZE : gasp_pkg::ST_SCAN_EV;
      end
      gasp_pkg::ST_SCAN_EV:  state_d = gasp_pkg::ST_SCAN_RD;
      gasp_pkg::ST_SIZE:     state_d = gasp_pkg::ST_PLACE_RD;
      gasp_pkg::ST_PLACE_RD: begin
        state_d = status_i.scan_end ? gasp_pkg::ST_PACK_OUT : gasp_pkg::ST_PLACE_EV;
      end
      gasp_pkg::ST_PLACE_EV: state_d = gasp_pkg::ST_PLACE_RD;
      gasp_pkg::ST_PACK_OUT: begin
        if (status_i.out_free) begin
          state_d = gasp_pkg::ST_IDLE;
        end
      end
      gasp_pkg::ST_QUERY_OUT: begin
        if (status_i.out_free) begin
          state_d = gasp_pkg::ST_IDLE;
        end
      end
      default: state_d = gasp_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready_o = 1'b0;
    cmd_o.op = gasp_pkg::CMD_NONE;
    unique case (state_q)
      gasp_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = (in_mode_i == gasp_pkg::MODE_QUERY) ? gasp_pkg::CMD_QUERY
                                                         : gasp_pkg::CMD_LOAD;
        end
      end
      gasp_pkg::ST_SCAN_RD: begin
        if (!status_i.scan_end) begin
          cmd_o.op = gasp_pkg::CMD_SCAN_RD;
        end
      end
      gasp_pkg::ST_SCAN_EV: cmd_o.op = gasp_pkg::CMD_SCAN_EV;
      gasp_pkg::ST_SIZE:    cmd_o.op = gasp_pkg::CMD_SIZE;
      gasp_pkg::ST_PLACE_RD: begin
        if (!status_i.scan_end) begin
          cmd_o.op = gasp_pkg::CMD_PLACE_RD;
        end
      end
      gasp_pkg::ST_PLACE_EV: cmd_o.op = gasp_pkg::CMD_PLACE_EV;
      gasp_pkg::ST_PACK_OUT: begin
        if (status_i.out_free) begin
          cmd_o.op = gasp_pkg::CMD_PACK_OUT;
        end
      end
      gasp_pkg::ST_QUERY_OUT: begin
        if (status_i.out_free) begin
          cmd_o.op = gasp_pkg::CMD_QUERY_OUT;
        end
      end
      default: cmd_o.op = gasp_pkg::CMD_NONE;
    endcase
  end

endmodule

// ===== hw/rtl/gasp_dp.sv =====
// ----------------------------------------------------------------------------
// gasp_dp
// Datapath: glyph tables, shelf cursors, size rounding and result register.
// ----------------------------------------------------------------------------
module gasp_dp #(
  parameter int unsigned MAX_GLYPHS = gasp_pkg::DEF_MAX_GLYPHS,
  parameter int unsigned START_WIDTH = gasp_pkg::DEF_START_WIDTH,
  parameter int unsigned MAX_WIDTH = gasp_pkg::DEF_MAX_WIDTH,
  parameter int unsigned MIN_SIZE = gasp_pkg::DEF_MIN_SIZE
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  input  logic [gasp_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [gasp_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  gasp_pkg::in_t                      in_data_i,
  input  gasp_pkg::ctrl_cmd_t                cmd_i,
  output gasp_pkg::dp_status_t               status_o,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output gasp_pkg::out_t                     out_data_o
);

  localparam int unsigned AW = (MAX_GLYPHS > 1) ? $clog2(MAX_GLYPHS) : 1;
  localparam int unsigned CW = $clog2(MAX_GLYPHS + 1);
  localparam int unsigned TOPW = (MAX_WIDTH > START_WIDTH) ? MAX_WIDTH : START_WIDTH;
  localparam int unsigned TW = $clog2(TOPW) + 2;
  localparam int unsigned RXW = (TW > 12) ? TW : 12;
  localparam int unsigned SW = RXW + 1;
  localparam int unsigned PW = gasp_pkg::PX_W + gasp_pkg::PY_W;
  localparam int unsigned GW = gasp_pkg::GW_W;

  logic [gasp_pkg::CODE_W-1:0] first_char_q;
  logic [gasp_pkg::RH_W-1:0]   row_height_q;
  logic [CW-1:0]               count_q;
  logic                        pvalid_q;
  logic [TW-1:0]               pw_q;
  logic [gasp_pkg::ATH_W-1:0]  ph_q;
  logic [TW-1:0]               tex_q;
  logic [RXW-1:0]              rx_q;
  logic [gasp_pkg::RY_W-1:0]   ry_q;
  logic [CW-1:0]               idx_q;
  logic                        hit_q;
  logic                        out_valid_q;
  gasp_pkg::out_t              out_q;

  logic [GW-1:0]               gw_sat;
  logic [CW-1:0]               cnt_eff;
  logic                        room;
  logic [gasp_pkg::CODE_W-1:0] qidx;
  logic                        qhit;
  logic [GW-1:0]               rd_w;
  logic [PW-1:0]               rd_pos;
  logic [SW-1:0]               sum;
  logic                        overflow;
  logic                        can_grow;
  logic [gasp_pkg::RY_W-1:0]   rh1;
  logic [RXW-1:0]              place_x;
  logic [gasp_pkg::RY_W-1:0]   place_y;
  logic [SW-1:0]               place_next;
  logic [gasp_pkg::P2_W-1:0]   h_raw;
  logic [gasp_pkg::P2_W-1:0]   w_raw;
  logic [gasp_pkg::P2_W-1:0]   h_fin;
  logic [gasp_pkg::P2_W-1:0]   w_fin;
  logic                        q_pres;
  logic                        out_load;

  logic                        w_we;
  logic                        w_re;
  logic [AW-1:0]               w_raddr;
  logic                        p_we;
  logic [PW-1:0]               p_wdata;

  assign gw_sat = (in_data_i.pix_width > gasp_pkg::WIDTH_SAT) ? gasp_pkg::WIDTH_SAT
                                                              : in_data_i.pix_width;
  // a load after packing starts a new set
  assign cnt_eff = pvalid_q ? '0 : count_q;
  assign room = cnt_eff < CW'(MAX_GLYPHS);
  assign qidx = in_data_i.char_code - first_char_q;
  assign qhit = pvalid_q && ({1'b0, qidx} < 9'(count_q));

  assign sum = SW'(rx_q) + SW'(rd_w) + SW'(1);
  assign overflow = sum > SW'(tex_q);
  assign can_grow = tex_q < TW'(MAX_WIDTH);
  assign rh1 = gasp_pkg::RY_W'(row_height_q) + gasp_pkg::RY_W'(1);

  assign place_x = overflow ? RXW'(1) : rx_q;
  assign place_y = overflow ? ry_q + rh1 : ry_q;
  assign place_next = SW'(place_x) + SW'(rd_w) + SW'(1);

  assign h_raw = gasp_pkg::pow2_ceil(gasp_pkg::P2_W'(ry_q) + gasp_pkg::P2_W'(rh1));
  assign w_raw = gasp_pkg::pow2_ceil(gasp_pkg::P2_W'(tex_q));
  assign h_fin = (h_raw < gasp_pkg::P2_W'(MIN_SIZE)) ? gasp_pkg::P2_W'(MIN_SIZE) : h_raw;
  assign w_fin = (w_raw < gasp_pkg::P2_W'(MIN_SIZE)) ? gasp_pkg::P2_W'(MIN_SIZE) : w_raw;

  assign q_pres = hit_q && (rd_w != '0);
  assign out_load = (cmd_i.op == gasp_pkg::CMD_PACK_OUT) ||
                    (cmd_i.op == gasp_pkg::CMD_QUERY_OUT);

  // table ports
  assign w_we = (cmd_i.op == gasp_pkg::CMD_LOAD) && room;
  assign w_re = (cmd_i.op == gasp_pkg::CMD_QUERY) || (cmd_i.op == gasp_pkg::CMD_SCAN_RD) ||
                (cmd_i.op == gasp_pkg::CMD_PLACE_RD);
  assign w_raddr = (cmd_i.op == gasp_pkg::CMD_QUERY) ? qidx[AW-1:0] : idx_q[AW-1:0];
  assign p_we = (cmd_i.op == gasp_pkg::CMD_PLACE_EV) && (rd_w != '0);
  assign p_wdata = {gasp_pkg::PX_W'(place_x), gasp_pkg::PY_W'(place_y)};

  gasp_ram #(
    .WIDTH(GW),
    .DEPTH(MAX_GLYPHS)
  ) u_width_ram (
    .clk_i  (clk_i),
    .we_i   (w_we),
    .waddr_i(cnt_eff[AW-1:0]),
    .wdata_i(gw_sat),
    .re_i   (w_re),
    .raddr_i(w_raddr),
    .rdata_o(rd_w)
  );

  gasp_ram #(
    .WIDTH(PW),
    .DEPTH(MAX_GLYPHS)
  ) u_pos_ram (
    .clk_i  (clk_i),
    .we_i   (p_we),
    .waddr_i(idx_q[AW-1:0]),
    .wdata_i(p_wdata),
    .re_i   (cmd_i.op == gasp_pkg::CMD_QUERY),
    .raddr_i(qidx[AW-1:0]),
    .rdata_o(rd_pos)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_char_q <= '0;
      row_height_q <= gasp_pkg::RH_W'(8);
      count_q      <= '0;
      pvalid_q     <= 1'b0;
      pw_q         <= TW'(START_WIDTH);
      ph_q         <= gasp_pkg::ATH_W'(MIN_SIZE);
      tex_q        <= TW'(START_WIDTH);
      rx_q         <= RXW'(1);
      ry_q         <= gasp_pkg::RY_W'(1);
      idx_q        <= '0;
      hit_q        <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          gasp_pkg::REG_FIRST_CHAR: first_char_q <= cfg_data_i;
          gasp_pkg::REG_ROW_HEIGHT: row_height_q <= cfg_data_i[gasp_pkg::RH_W-1:0];
          default: ;
        endcase
      end

      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      unique case (cmd_i.op)
        gasp_pkg::CMD_LOAD: begin
          pvalid_q <= 1'b0;
          count_q  <= room ? cnt_eff + CW'(1) : cnt_eff;
          tex_q    <= TW'(START_WIDTH);
          rx_q     <= RXW'(1);
          ry_q     <= gasp_pkg::RY_W'(1);
          idx_q    <= '0;
        end
        gasp_pkg::CMD_QUERY: hit_q <= qhit;
        gasp_pkg::CMD_SCAN_EV: begin
          if (rd_w == '0) begin
            idx_q <= idx_q + CW'(1);
          end else if (overflow && can_grow) begin
            // widen the atlas and lay out again from the first glyph
            tex_q <= tex_q << 1;
            rx_q  <= RXW'(1);
            ry_q  <= gasp_pkg::RY_W'(1);
            idx_q <= '0;
          end else begin
            rx_q  <= RXW'(place_next);
            ry_q  <= place_y;
            idx_q <= idx_q + CW'(1);
          end
        end
        gasp_pkg::CMD_SIZE: begin
          ph_q  <= gasp_pkg::ATH_W'(h_fin);
          pw_q  <= TW'(w_fin);
          tex_q <= TW'(w_fin);
          rx_q  <= RXW'(1);
          ry_q  <= gasp_pkg::RY_W'(1);
          idx_q <= '0;
        end
        gasp_pkg::CMD_PLACE_EV: begin
          if (rd_w != '0) begin
            rx_q <= RXW'(place_next);
            ry_q <= place_y;
          end
          idx_q <= idx_q + CW'(1);
        end
        gasp_pkg::CMD_PACK_OUT: pvalid_q <= 1'b1;
        default: ;
      endcase
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q.atlas_width  <= gasp_pkg::ATW_W'(pw_q);
      out_q.atlas_height <= ph_q;
      if (cmd_i.op == gasp_pkg::CMD_QUERY_OUT) begin
        out_q.result_kind <= gasp_pkg::KIND_QUERY;
        out_q.present     <= q_pres;
        out_q.pos_x       <= q_pres ? rd_pos[PW-1:gasp_pkg::PY_W] : '0;
        out_q.pos_y       <= q_pres ? rd_pos[gasp_pkg::PY_W-1:0] : '0;
        out_q.width_out   <= q_pres ? rd_w : '0;
      end else begin
        out_q.result_kind <= gasp_pkg::KIND_PACK;
        out_q.present     <= 1'b0;
        out_q.pos_x       <= '0;
        out_q.pos_y       <= '0;
        out_q.width_out   <= '0;
      end
    end
  end

  assign status_o.scan_end = (idx_q == count_q);
  assign status_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o = out_q;

endmodule

// ===== hw/rtl/glyph_atlas_shelf_packer.sv =====
// ----------------------------------------------------------------------------
// glyph_atlas_shelf_packer
// Loads glyph widths, packs them into shelves of a power of two atlas and
// answers per glyph position queries.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  in      | input     | in_valid_i/in_ready_o  | in_data_i (in_t)
//  out     | output    | out_valid_o/out_ready_i| out_data_o (out_t)
//  cfg     | input     | cfg_valid_i/cfg_ready_o| cfg_index_i, cfg_data_i
//
//  a load is taken in idle; a query waits on its registered table read
//  a last load packs: width passes (one per doubling plus one) read and
//  evaluate each glyph, then sizes are rounded and a placement pass runs
//  reset clears the counters and sizes; tables need no clearing pass
//  a result waiting on out_ready_i stalls only the next result, not loads
// ----------------------------------------------------------------------------
module glyph_atlas_shelf_packer #(
  parameter int unsigned MAX_GLYPHS = gasp_pkg::DEF_MAX_GLYPHS,
  parameter int unsigned START_WIDTH = gasp_pkg::DEF_START_WIDTH,
  parameter int unsigned MAX_WIDTH = gasp_pkg::DEF_MAX_WIDTH,
  parameter int unsigned MIN_SIZE = gasp_pkg::DEF_MIN_SIZE
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  gasp_pkg::in_t                    in_data_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output gasp_pkg::out_t                   out_data_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [gasp_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [gasp_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  gasp_pkg::ctrl_cmd_t  cmd;
  gasp_pkg::dp_status_t status;

  assign cfg_ready_o = 1'b1;

  gasp_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_mode_i (in_data_i.mode),
    .in_last_i (in_data_i.last_glyph),
    .status_i  (status),
    .in_ready_o(in_ready_o),
    .cmd_o     (cmd)
  );

  gasp_dp #(
    .MAX_GLYPHS (MAX_GLYPHS),
    .START_WIDTH(START_WIDTH),
    .MAX_WIDTH  (MAX_WIDTH),
    .MIN_SIZE   (MIN_SIZE)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .status_o   (status),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  // a query request occupies the block until its answer is registered
  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (in_data_i.mode == gasp_pkg::MODE_QUERY) |=> !in_ready_o)
    else $error("input accepted while a query is pending");

  // a load without the last mark gives no result
  a_load_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (in_data_i.mode == gasp_pkg::MODE_LOAD) &&
    !in_data_i.last_glyph && !out_valid_o |=> !out_valid_o)
    else $error("result appeared after a plain load");

  a_present_width: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.present |->
    (out_data_o.width_out != '0) && (out_data_o.result_kind == gasp_pkg::KIND_QUERY))
    else $error("present glyph without width");

  a_pack_height: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.result_kind == gasp_pkg::KIND_PACK) |->
    (out_data_o.atlas_height != '0) && !out_data_o.present)
    else $error("packing result with bad height");

endmodule

// ===== test/glyph_atlas_shelf_packer_test.sv =====
// ----------------------------------------------------------------------------
// glyph_atlas_shelf_packer_test
// Self-checking bench for the shelf packer. Glyph sets are loaded, packed and
// queried through the request channel; each result is compared field by field
// against an in-bench packing and lookup model or a typed step's fixed result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module glyph_atlas_shelf_packer_test;
  import gasp_pkg::*;

  localparam int unsigned CLK_HALF = 4;
  localparam int unsigned GAP_MAX = 6;
  localparam int unsigned RANDOM_ITEMS = 550;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned STALL_LIMIT = 20000;

  typedef struct {
    in_t  req;
    bit   typed;
    out_t res;
  } step_row_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_ready_o;
  in_t                   in_data_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  out_t                  out_data_o;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  // model of the atlas
  int unsigned glyph_w [256];
  int unsigned glyph_x [256];
  int unsigned glyph_y [256];
  int unsigned glyph_total;
  int unsigned atlas_w;
  int unsigned atlas_h;
  bit          layout_valid;
  int unsigned cfg_first;
  int unsigned cfg_height;

  out_t        pending_results [$];
  step_row_t   directed_steps [$];
  int unsigned error_count;
  int unsigned request_count;
  int unsigned idle_cycles;
  bit          steady_flow;

  glyph_atlas_shelf_packer u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #(CLK_HALF) clk_i = ~clk_i;
  end

  function automatic int unsigned round_pow2(input int unsigned v);
    int unsigned p;
    p = 1;
    while (p < v) p = p << 1;
    if (p < DEF_MIN_SIZE) p = DEF_MIN_SIZE;
    return p;
  endfunction

  function automatic void pack_atlas();
    int unsigned tex;
    int unsigned cx;
    int unsigned cy;
    bit          redo;
    tex = DEF_START_WIDTH;
    redo = 1'b1;
    // widen and start over while a glyph overflows its row and the width can grow
    while (redo) begin
      redo = 1'b0;
      cx = 1;
      cy = 1;
      for (int i = 0; i < glyph_total; i++) begin
        if (glyph_w[i] == 0) continue;
        if (cx + glyph_w[i] + 1 > tex) begin
          if (tex < DEF_MAX_WIDTH) begin
            tex = tex << 1;
            redo = 1'b1;
            break;
          end
          cx = 1;
          cy = cy + cfg_height + 1;
        end
        cx = cx + glyph_w[i] + 1;
      end
    end
    atlas_h = round_pow2(cy + cfg_height + 1);
    atlas_w = round_pow2(tex);
    cx = 1;
    cy = 1;
    for (int i = 0; i < glyph_total; i++) begin
      if (glyph_w[i] == 0) continue;
      if (cx + glyph_w[i] + 1 > atlas_w) begin
        cx = 1;
        cy = cy + cfg_height + 1;
      end
      glyph_x[i] = cx;
      glyph_y[i] = cy;
      cx = cx + glyph_w[i] + 1;
    end
    layout_valid = 1'b1;
  endfunction

  // advances the model by one request, returns 1 when a result follows
  function automatic bit atlas_step(input in_t req, output out_t res);
    int unsigned w;
    int unsigned slot;
    res = '0;
    if (req.mode == MODE_LOAD) begin
      if (layout_valid) begin
        glyph_total = 0;
        layout_valid = 1'b0;
      end
      w = (req.pix_width > WIDTH_SAT) ? WIDTH_SAT : req.pix_width;
      // loads past a full table are dropped
      if (glyph_total < DEF_MAX_GLYPHS) begin
        glyph_w[glyph_total] = w;
        glyph_total++;
      end
      if (!req.last_glyph) return 1'b0;
      pack_atlas();
      res.result_kind = KIND_PACK;
    end else begin
      slot = (32'(req.char_code) - cfg_first) & 32'hFF;
      res.result_kind = KIND_QUERY;
      if (layout_valid && slot < glyph_total && glyph_w[slot] != 0) begin
        res.pos_x = PX_W'(glyph_x[slot]);
        res.pos_y = PY_W'(glyph_y[slot]);
        res.width_out = GW_W'(glyph_w[slot]);
        res.present = 1'b1;
      end
    end
    res.atlas_width = ATW_W'(atlas_w);
    res.atlas_height = ATH_W'(atlas_h);
    return 1'b1;
  endfunction

  task automatic report_error(input string msg);
    $display("ERROR at %0t: %s", $time, msg);
    error_count++;
  endtask

  task automatic check_result(input out_t got);
    out_t want;
    if (pending_results.size() == 0) begin
      report_error($sformatf("result 0x%0h with nothing outstanding", got));
      return;
    end
    want = pending_results.pop_front();
    if (got.result_kind !== want.result_kind)
      report_error($sformatf("result_kind %0d, want %0d", got.result_kind, want.result_kind));
    if (got.atlas_width !== want.atlas_width)
      report_error($sformatf("atlas_width %0d, want %0d", got.atlas_width, want.atlas_width));
    if (got.atlas_height !== want.atlas_height)
      report_error($sformatf("atlas_height %0d, want %0d", got.atlas_height,
                             want.atlas_height));
    if (got.pos_x !== want.pos_x)
      report_error($sformatf("pos_x %0d, want %0d", got.pos_x, want.pos_x));
    if (got.pos_y !== want.pos_y)
      report_error($sformatf("pos_y %0d, want %0d", got.pos_y, want.pos_y));
    if (got.width_out !== want.width_out)
      report_error($sformatf("width_out %0d, want %0d", got.width_out, want.width_out));
    if (got.present !== want.present)
      report_error($sformatf("present %0d, want %0d", got.present, want.present));
  endtask

  task automatic push_request(input in_t req, input bit typed, input out_t typed_res);
    int unsigned gap;
    out_t        res;
    gap = steady_flow ? 0 : $urandom_range(0, GAP_MAX);
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_data_i = req;
    in_valid_i = 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    request_count++;
    if (atlas_step(req, res)) pending_results.push_back(typed ? typed_res : res);
  endtask

  task automatic query_glyph(input int unsigned code);
    in_t req;
    req.mode = MODE_QUERY;
    req.pix_width = GW_W'($urandom_range(0, 2047));
    req.last_glyph = 1'($urandom_range(0, 1));
    req.char_code = CODE_W'(code);
    push_request(req, 1'b0, '0);
  endtask

  // drop valid, wait for every result, then let the block drain
  task automatic settle_idle();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_index_i = idx;
    cfg_data_i = data;
    cfg_valid_i = 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == REG_FIRST_CHAR) cfg_first = data;
    else if (idx == REG_ROW_HEIGHT) cfg_height = data & 8'h3F;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  function automatic void add_step(input in_t req, input bit typed, input out_t res);
    step_row_t row;
    row.req = req;
    row.typed = typed;
    row.res = res;
    directed_steps.push_back(row);
  endfunction

  // result side
  initial begin
    int unsigned stall;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = steady_flow ? 0 : $urandom_range(0, GAP_MAX);
      @(negedge clk_i);
      out_ready_i = (stall == 0);
      repeat (stall) @(negedge clk_i);
      out_ready_i = 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      check_result(out_data_o);
    end
  end

  // no handshake for too long means a hang
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
          $display("Testbench completed WITH ERRORS");
          $finish;
        end
      end
    end
  end

  initial begin
    int unsigned n;
    int unsigned style;
    int unsigned phase;
    int unsigned w;
    int unsigned k;
    bit          broken;
    in_t         req;

    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    error_count = 0;
    request_count = 0;
    idle_cycles = 0;
    steady_flow = 1'b0;
    glyph_total = 0;
    atlas_w = DEF_START_WIDTH;
    atlas_h = DEF_MIN_SIZE;
    layout_valid = 1'b0;
    cfg_first = 0;
    cfg_height = 8;
    foreach (glyph_w[i]) begin
      glyph_w[i] = 0;
      glyph_x[i] = 0;
      glyph_y[i] = 0;
    end

    // query before any packing, empty set
    add_step({MODE_QUERY, 11'd2047, 1'b1, 8'd0}, 1'b1,
             {KIND_QUERY, 12'd256, 16'd64, 11'd0, 14'd0, 11'd0, 1'b0});
    add_step({MODE_LOAD, 11'd0, 1'b1, 8'hFF}, 1'b1,
             {KIND_PACK, 12'd256, 16'd64, 11'd0, 14'd0, 11'd0, 1'b0});
    add_step({MODE_QUERY, 11'd0, 1'b0, 8'd0}, 1'b1,
             {KIND_QUERY, 12'd256, 16'd64, 11'd0, 14'd0, 11'd0, 1'b0});
    // saturated widths force the widest atlas and row wraps
    add_step({MODE_LOAD, 11'd2047, 1'b0, 8'd0}, 1'b0, '0);
    add_step({MODE_LOAD, 11'd2046, 1'b0, 8'h5A}, 1'b0, '0);
    add_step({MODE_LOAD, 11'd0, 1'b0, 8'd0}, 1'b0, '0);
    add_step({MODE_LOAD, 11'd5, 1'b1, 8'd0}, 1'b1,
             {KIND_PACK, 12'd2048, 16'd64, 11'd0, 14'd0, 11'd0, 1'b0});
    add_step({MODE_QUERY, 11'd0, 1'b0, 8'd0}, 1'b1,
             {KIND_QUERY, 12'd2048, 16'd64, 11'd1, 14'd1, 11'd2046, 1'b1});
    add_step({MODE_QUERY, 11'h555, 1'b0, 8'd1}, 1'b0, '0);
    add_step({MODE_QUERY, 11'd0, 1'b1, 8'd2}, 1'b0, '0);
    add_step({MODE_QUERY, 11'h2AA, 1'b0, 8'd3}, 1'b0, '0);
    add_step({MODE_QUERY, 11'd0, 1'b0, 8'd4}, 1'b0, '0);
    add_step({MODE_QUERY, 11'd0, 1'b0, 8'd255}, 1'b0, '0);
    // one and two doublings
    add_step({MODE_LOAD, 11'd300, 1'b0, 8'd0}, 1'b0, '0);
    add_step({MODE_LOAD, 11'd1, 1'b1, 8'd0}, 1'b0, '0);
    add_step({MODE_QUERY, 11'd0, 1'b0, 8'd1}, 1'b0, '0);
    add_step({MODE_LOAD, 11'd700, 1'b1, 8'd0}, 1'b0, '0);
    add_step({MODE_QUERY, 11'd0, 1'b0, 8'd0}, 1'b0, '0);

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (directed_steps[i])
      push_request(directed_steps[i].req, directed_steps[i].typed, directed_steps[i].res);

    phase = 0;
    while (request_count < directed_steps.size() + RANDOM_ITEMS) begin
      if (phase % 7 == 6) settle_idle();
      steady_flow = ($urandom_range(0, 3) == 0);
      style = $urandom_range(0, 2);
      if (phase == 5) begin
        // overfill the table with wide glyphs
        n = DEF_MAX_GLYPHS + 4;
        style = 1;
      end else if ($urandom_range(0, 9) == 0) begin
        n = $urandom_range(30, 80);
      end else begin
        n = $urandom_range(1, 12);
      end
      broken = (phase != 5) && ($urandom_range(0, 7) == 0);
      for (int i = 0; i < n; i++) begin
        case (style)
          0: w = $urandom_range(1, 60);
          1: w = $urandom_range(0, 2047);
          default: w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 700);
        endcase
        req.mode = MODE_LOAD;
        req.pix_width = GW_W'(w);
        req.last_glyph = (i == n - 1) && !broken;
        req.char_code = CODE_W'($urandom_range(0, 255));
        push_request(req, 1'b0, '0);
        if (i < n - 1 && $urandom_range(0, 9) == 0) query_glyph($urandom_range(0, 255));
      end
      // every third phase, registers change between packing and the queries that follow
      if (phase % 3 == 0) begin
        settle_idle();
        case (phase)
          0: begin
            write_reg(REG_FIRST_CHAR, 8'd255);
            write_reg(REG_ROW_HEIGHT, 8'd63);
          end
          3: begin
            write_reg(REG_FIRST_CHAR, 8'd0);
            write_reg(REG_ROW_HEIGHT, 8'd1);
          end
          default: begin
            write_reg(REG_FIRST_CHAR, CFG_DATA_W'($urandom_range(0, 255)));
            write_reg(REG_ROW_HEIGHT, CFG_DATA_W'($urandom_range(1, 63)));
          end
        endcase
      end
      k = $urandom_range(1, 10);
      repeat (k) begin
        if ($urandom_range(0, 4) == 0) query_glyph($urandom_range(0, 255));
        else query_glyph((cfg_first + $urandom_range(0, n + 1)) & 32'hFF);
      end
      phase++;
    end

    steady_flow = 1'b0;
    settle_idle();
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/gasp_pkg.sv
hw/rtl/gasp_ram.sv
hw/rtl/gasp_ctrl.sv
hw/rtl/gasp_dp.sv
hw/rtl/glyph_atlas_shelf_packer.sv
test/glyph_atlas_shelf_packer_test.sv
